[sv/bbrc_pkg.sv]
// ---------------------------------------------------------------------------
// bbrc_pkg
// Shared widths, status codes and item types for the bad-block range table.
// ---------------------------------------------------------------------------
package bbrc_pkg;

   // Field widths of the command and result items.
   localparam int START_W = 54;
   localparam int COUNT_W = 31;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W = 10;
   localparam int SHIFT_W = 4;

   // Width of sector arithmetic: a start plus a count, or a rounded start.
   localparam int EXT_W = START_W + 1;

   // Default table geometry.
   localparam int DEF_TABLE_DEPTH = 512;
   localparam int DEF_MAX_RANGE_LEN = 512;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_APPEND_REJECT = 2'd2;

   // Command codes.
   localparam logic CMD_CLEAR = 1'b0;
   localparam logic CMD_APPEND = 1'b1;

   // Register index of block_shift.
   localparam logic REG_BLOCK_SHIFT = 1'b0;

   typedef struct packed {
      logic cmd;
      logic [START_W-1:0] start_sector;
      logic [COUNT_W-1:0] sector_count;
      logic ack_bit;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0] entry_count;
      logic changed_flag;
   } rsp_item_type;

endpackage

[sv/bad_block_range_clear_unit.sv]
// ---------------------------------------------------------------------------
// bad_block_range_clear_unit
// Sorted table of bad-block ranges held in one memory, with range clear
// (trim, split, delete) and append commands.
// ---------------------------------------------------------------------------
//  channel   ports                         handshake
//  command   start, busy, req_item         taken when start and not busy
//  result    rsp_valid, rsp_item           one-cycle strobe, cannot stall
//  config    psel..pready, paddr, p*data   APB write on access phase
//
// An append is checked and written in S_APP after it is taken; an empty clear
// ends after S_ROUND and S_CHECK. Any other clear reads one entry per
// binary-search probe and per entry walked back, and reads and writes each
// entry shifted up on a split or moved down after deleted ranges; the single
// memory port pair sets these costs. Reset is synchronous and empties the
// table at once (no clearing pass). The result strobe comes in the first
// cycle in which busy is low, and a new item may start then.
// ---------------------------------------------------------------------------
module bad_block_range_clear_unit
   import bbrc_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int MAX_RANGE_LEN = DEF_MAX_RANGE_LEN
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_item_type req_item,
   output logic rsp_valid,
   output rsp_item_type rsp_item,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [2:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int LEN_W = $clog2(MAX_RANGE_LEN + 1);
   localparam int ENT_W = START_W + LEN_W + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_ROUND, S_CHECK, S_SRCH, S_SRCH_W, S_LO, S_SHIFT_R, S_SHIFT_W,
      S_SPLIT, S_SPLIT2, S_BACK, S_BACK_W, S_MOVE_R, S_MOVE_W, S_APP
   } state_type;

   state_type state_ff, state_in;
   req_item_type item_ff, item_in;
   logic [EXT_W-1:0] s_ff, s_in, t_ff, t_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0] mid_ff, mid_in, d_ff, d_in, w_ff, w_in;
   logic [ENT_W-1:0] e_ff, e_in;
   logic changed_ff, changed_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [SHIFT_W-1:0] shift_ff;

   // Memory ports.
   logic [ENT_W-1:0] mem [TABLE_DEPTH];
   logic [ENT_W-1:0] rdata_ff;
   logic mem_we;
   logic [IDX_W-1:0] mem_wa, mem_ra;
   logic [ENT_W-1:0] mem_wd;

   // Fields of the entry just read.
   logic [START_W-1:0] r_start;
   logic [LEN_W-1:0] r_len;
   logic r_ack;
   logic [EXT_W-1:0] r_start_x, r_end, e_start_x, e_end, round_add;
   logic [EXT_W-1:0] diff_s, diff_t, e_diff_s, e_diff_t, app_end;
   logic [CNT_W:0] mid_sum;

   assign r_start = rdata_ff[START_W-1:0];
   assign r_len = rdata_ff[START_W +: LEN_W];
   assign r_ack = rdata_ff[ENT_W-1];
   assign r_start_x = {1'b0, r_start};
   assign r_end = r_start_x + EXT_W'(r_len);
   assign e_start_x = {1'b0, e_ff[START_W-1:0]};
   assign e_end = e_start_x + EXT_W'(e_ff[START_W +: LEN_W]);
   assign diff_s = s_ff - r_start_x;
   assign diff_t = r_end - t_ff;
   assign e_diff_s = s_ff - e_start_x;
   assign e_diff_t = e_end - t_ff;
   assign round_add = (EXT_W'(1) << shift_ff) - EXT_W'(1);
   assign app_end = {1'b0, item_ff.start_sector} + EXT_W'(item_ff.sector_count);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   // Memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[mem_ra];
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      s_in = s_ff;
      t_in = t_ff;
      cnt_in = cnt_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      d_in = d_ff;
      w_in = w_ff;
      e_in = e_ff;
      changed_in = changed_ff;
      status_in = status_ff;
      rsp_valid_in = 1'b0;
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = rdata_ff;
      mem_ra = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               item_in = req_item;
               if (req_item.cmd == CMD_APPEND) begin
                  mem_ra = IDX_W'(cnt_ff - CNT_W'(1));
                  state_in = S_APP;
               end else begin
                  state_in = S_ROUND;
               end
            end
         end
         S_ROUND: begin
            s_in = ({1'b0, item_ff.start_sector} + round_add) >> shift_ff;
            t_in = ({1'b0, item_ff.start_sector} + EXT_W'(item_ff.sector_count))
                   >> shift_ff;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (s_ff >= t_ff || cnt_ff == '0) begin
               changed_in = 1'b1;
               status_in = ST_OK;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               lo_in = '0;
               hi_in = cnt_ff;
               state_in = S_SRCH;
            end
         end
         // Binary search for the last range starting before the end.
         S_SRCH: begin
            if (hi_ff - lo_ff > CNT_W'(1)) begin
               mid_in = mid_sum[CNT_W:1];
               mem_ra = mid_sum[IDX_W:1];
               state_in = S_SRCH_W;
            end else begin
               mem_ra = lo_ff[IDX_W-1:0];
               state_in = S_LO;
            end
         end
         S_SRCH_W: begin
            if (r_start_x < t_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SRCH;
         end
         S_LO: begin
            e_in = rdata_ff;
            if (r_start_x >= t_ff) begin
               changed_in = 1'b1;
               status_in = ST_OK;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else if (r_end > t_ff) begin
               if (r_start_x < s_ff) begin
                  if (cnt_ff >= CNT_W'(TABLE_DEPTH)) begin
                     status_in = ST_NO_SPACE;
                     rsp_valid_in = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     w_in = cnt_ff;
                     state_in = S_SHIFT_R;
                  end
               end else begin
                  // Trim the head of the range.
                  mem_we = 1'b1;
                  mem_wa = lo_ff[IDX_W-1:0];
                  mem_wd = {r_ack, diff_t[LEN_W-1:0], t_ff[START_W-1:0]};
                  hi_in = lo_ff;
                  d_in = lo_ff;
                  state_in = S_BACK;
               end
            end else begin
               hi_in = lo_ff + CNT_W'(1);
               d_in = lo_ff + CNT_W'(1);
               state_in = S_BACK;
            end
         end
         // Open a gap at the split range by moving entries up one place.
         S_SHIFT_R: begin
            if (w_ff > lo_ff) begin
               mem_ra = IDX_W'(w_ff - CNT_W'(1));
               state_in = S_SHIFT_W;
            end else begin
               state_in = S_SPLIT;
            end
         end
         S_SHIFT_W: begin
            mem_we = 1'b1;
            mem_wa = w_ff[IDX_W-1:0];
            w_in = w_ff - CNT_W'(1);
            state_in = S_SHIFT_R;
         end
         S_SPLIT: begin
            mem_we = 1'b1;
            mem_wa = lo_ff[IDX_W-1:0];
            mem_wd = {e_ff[ENT_W-1], e_diff_s[LEN_W-1:0], e_ff[START_W-1:0]};
            state_in = S_SPLIT2;
         end
         S_SPLIT2: begin
            mem_we = 1'b1;
            mem_wa = IDX_W'(lo_ff + CNT_W'(1));
            mem_wd = {e_ff[ENT_W-1], e_diff_t[LEN_W-1:0], t_ff[START_W-1:0]};
            cnt_in = cnt_ff + CNT_W'(1);
            changed_in = 1'b1;
            status_in = ST_OK;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         // Walk back over ranges that end inside the cleared span.
         S_BACK: begin
            if (d_ff == '0) begin
               w_in = d_ff;
               state_in = S_MOVE_R;
            end else begin
               mem_ra = IDX_W'(d_ff - CNT_W'(1));
               state_in = S_BACK_W;
            end
         end
         S_BACK_W: begin
            if (r_end > s_ff) begin
               if (r_start_x < s_ff) begin
                  mem_we = 1'b1;
                  mem_wa = IDX_W'(d_ff - CNT_W'(1));
                  mem_wd = {r_ack, diff_s[LEN_W-1:0], r_start};
                  w_in = d_ff;
                  state_in = S_MOVE_R;
               end else begin
                  d_in = d_ff - CNT_W'(1);
                  state_in = S_BACK;
               end
            end else begin
               w_in = d_ff;
               state_in = S_MOVE_R;
            end
         end
         // Close the hole left by deleted ranges: hi is source, w is target.
         S_MOVE_R: begin
            if (hi_ff > w_ff && hi_ff < cnt_ff) begin
               mem_ra = hi_ff[IDX_W-1:0];
               state_in = S_MOVE_W;
            end else begin
               if (hi_ff > w_ff) begin
                  cnt_in = w_ff;
               end
               changed_in = 1'b1;
               status_in = ST_OK;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_MOVE_W: begin
            mem_we = 1'b1;
            mem_wa = w_ff[IDX_W-1:0];
            w_in = w_ff + CNT_W'(1);
            hi_in = hi_ff + CNT_W'(1);
            state_in = S_MOVE_R;
         end
         // Append: check room, count, end and overlap with the last entry, then write at the end.
         S_APP: begin
            if (cnt_ff >= CNT_W'(TABLE_DEPTH) || item_ff.sector_count == '0 ||
                item_ff.sector_count > COUNT_W'(MAX_RANGE_LEN) ||
                app_end > (EXT_W'(1) << START_W) ||
                (cnt_ff != '0 && {1'b0, item_ff.start_sector} < r_end)) begin
               status_in = ST_APPEND_REJECT;
            end else begin
               mem_we = 1'b1;
               mem_wa = cnt_ff[IDX_W-1:0];
               mem_wd = {item_ff.ack_bit, item_ff.sector_count[LEN_W-1:0],
                         item_ff.start_sector};
               cnt_in = cnt_ff + CNT_W'(1);
               status_in = ST_OK;
            end
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, table count, result and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         changed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff <= ST_OK;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         changed_ff <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff <= status_in;
      end
      item_ff <= item_in;
      s_ff <= s_in;
      t_ff <= t_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      d_ff <= d_in;
      w_ff <= w_in;
      e_ff <= e_in;
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else if (psel && penable && pwrite && paddr[2] == REG_BLOCK_SHIFT) begin
         shift_ff <= pwdata[SHIFT_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_BLOCK_SHIFT) ? {{(32-SHIFT_W){1'b0}}, shift_ff} : '0;

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item.status = status_ff;
   assign rsp_item.entry_count = ENTRY_W'(cnt_ff);
   assign rsp_item.changed_flag = changed_ff;

   // The table never holds more entries than it has room for.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // A result follows a cycle in which the block was busy.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a command in flight");

   // A no-space status only happens on a full table, left unchanged.
   a_nospace_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status_ff == ST_NO_SPACE) |-> cnt_ff == CNT_W'(TABLE_DEPTH))
      else $error("no-space status on a table that is not full");

   // The block is idle again when it shows a result.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

endmodule

[tb/tb_bad_block_range_clear_unit.sv]
// ---------------------------------------------------------------------------
// tb_bad_block_range_clear_unit
// Self-checking testbench for the bad-block range table. Commands are sent
// with random gaps and predicted by a behavioral copy of the table; every
// result strobe is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_bad_block_range_clear_unit;
   import bbrc_pkg::*;

   localparam int DEPTH = DEF_TABLE_DEPTH;
   localparam int MAX_LEN = DEF_MAX_RANGE_LEN;
   localparam longint unsigned START_TOP = 64'd1 << START_W;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_item_type req_item = '0;
   logic rsp_valid;
   rsp_item_type rsp_item;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // Predicted table state.
   longint unsigned tbl_start [DEPTH];
   int unsigned tbl_len [DEPTH];
   bit tbl_ack [DEPTH];
   int tbl_total = 0;
   bit tbl_changed = 1'b0;
   logic [SHIFT_W-1:0] cur_shift = '0;

   rsp_item_type expected_results [$];
   int errors = 0;
   int stall_cycles = 0;
   bit gaps_on = 1'b1;

   bad_block_range_clear_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #4 clock = ~clock;

   // Predict the effect of a clear command on the table.
   function automatic logic [STATUS_W-1:0] clear_span(longint unsigned s,
                                                      longint unsigned n);
      longint unsigned tgt, a, e;
      int lo, hi, mid, cnt;
      bit ak;
      tgt = s + n;
      cnt = tbl_total;
      lo = 0;
      hi = cnt;
      if (cur_shift > 0) begin
         s = (s + ((64'd1 << cur_shift) - 1)) >> cur_shift;
         tgt = tgt >> cur_shift;
      end
      if (s >= tgt || cnt == 0) begin
         tbl_changed = 1'b1;
         return ST_OK;
      end
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (tbl_start[mid] < tgt) lo = mid;
         else hi = mid;
      end
      if (tbl_start[lo] >= tgt) begin
         tbl_changed = 1'b1;
         return ST_OK;
      end
      // The last range reaching past the span keeps its tail, and maybe a head.
      if (tbl_start[lo] + tbl_len[lo] > tgt) begin
         ak = tbl_ack[lo];
         a = tbl_start[lo];
         e = a + tbl_len[lo];
         if (a < s) begin
            if (cnt >= DEPTH) return ST_NO_SPACE;
            for (int i = cnt; i > lo; i--) begin
               tbl_start[i] = tbl_start[i-1];
               tbl_len[i] = tbl_len[i-1];
               tbl_ack[i] = tbl_ack[i-1];
            end
            cnt++;
            tbl_len[lo] = int'(s - a);
            lo++;
         end
         tbl_start[lo] = tgt;
         tbl_len[lo] = int'(e - tgt);
         tbl_ack[lo] = ak;
         hi = lo;
         lo--;
      end
      // Walk back over ranges inside the span; trim the one that starts before it.
      while (lo >= 0 && tbl_start[lo] + tbl_len[lo] > s) begin
         if (tbl_start[lo] < s) begin
            tbl_len[lo] = int'(s - tbl_start[lo]);
            break;
         end
         lo--;
      end
      if (hi - lo > 1) begin
         for (int i = hi; i < cnt; i++) begin
            tbl_start[lo + 1 + i - hi] = tbl_start[i];
            tbl_len[lo + 1 + i - hi] = tbl_len[i];
            tbl_ack[lo + 1 + i - hi] = tbl_ack[i];
         end
         cnt -= hi - lo - 1;
      end
      tbl_total = cnt;
      tbl_changed = 1'b1;
      return ST_OK;
   endfunction

   // Predict an append of one entry at the end of the table.
   function automatic logic [STATUS_W-1:0] append_entry(longint unsigned s,
                                                        longint unsigned n, bit ak);
      if (tbl_total >= DEPTH || n == 0 || n > MAX_LEN) return ST_APPEND_REJECT;
      if (s + n > START_TOP) return ST_APPEND_REJECT;
      if (tbl_total > 0 && s < tbl_start[tbl_total-1] + tbl_len[tbl_total-1])
         return ST_APPEND_REJECT;
      tbl_start[tbl_total] = s;
      tbl_len[tbl_total] = int'(n);
      tbl_ack[tbl_total] = ak;
      tbl_total++;
      return ST_OK;
   endfunction

   function automatic rsp_item_type predict_command(req_item_type it);
      rsp_item_type r;
      if (it.cmd == CMD_CLEAR)
         r.status = clear_span(64'(it.start_sector), 64'(it.sector_count));
      else
         r.status = append_entry(64'(it.start_sector), 64'(it.sector_count), it.ack_bit);
      r.entry_count = tbl_total[ENTRY_W-1:0];
      r.changed_flag = tbl_changed;
      return r;
   endfunction

   // Send one item after a random gap and record its predicted result.
   task automatic send_item(logic c, longint unsigned s, longint unsigned n, bit ak);
      int gap;
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= req_item_type'{c, s[START_W-1:0], n[COUNT_W-1:0], ak};
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_results.push_back(predict_command(
         req_item_type'{c, s[START_W-1:0], n[COUNT_W-1:0], ak}));
   endtask

   // Stop sending and wait until every expected result has arrived.
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write block_shift through the register port; the table must be idle.
   task automatic write_shift(logic [SHIFT_W-1:0] v);
      drain();
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= '0;
      pwdata <= 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      cur_shift = v;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Empty the table with clears from the first entry onward.
   task automatic clear_table;
      write_shift(0);
      while (tbl_total > 0) send_item(CMD_CLEAR, tbl_start[0], 64'h7FFF_FFFF, 0);
   endtask

   // A clear aimed at the stored ranges, expressed in sectors.
   task automatic send_aimed_clear;
      int idx;
      longint unsigned b, spanb, s, n, unit;
      unit = 64'd1 << cur_shift;
      if (tbl_total == 0) begin
         send_item(CMD_CLEAR, $urandom_range(0, 5000), $urandom_range(0, 5000), 0);
         return;
      end
      idx = $urandom_range(0, tbl_total - 1);
      b = tbl_start[idx] + $urandom_range(0, tbl_len[idx]);
      spanb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1500) : $urandom_range(0, 40);
      s = b << cur_shift;
      if (s > 0) s = s - (64'($urandom) % (s < unit ? s : unit));
      n = (spanb << cur_shift) + (64'($urandom) % unit);
      send_item(CMD_CLEAR, s, n, 1'($urandom_range(0, 1)));
   endtask

   // A well-formed append just past the last entry.
   task automatic send_good_append;
      longint unsigned base;
      int unsigned ln;
      base = (tbl_total > 0) ? tbl_start[tbl_total-1] + tbl_len[tbl_total-1]
                             : $urandom_range(0, 3000);
      ln = ($urandom_range(0, 3) == 0) ? MAX_LEN : $urandom_range(1, MAX_LEN);
      send_item(CMD_APPEND, base + $urandom_range(0, 600), ln,
                1'($urandom_range(0, 1)));
   endtask

   task automatic test_directed;
      // Appends that must be rejected, then edge entries.
      send_item(CMD_CLEAR, 0, 10, 0);
      send_item(CMD_APPEND, START_TOP - 1, 2, 0);
      send_item(CMD_APPEND, 100, 0, 1);
      send_item(CMD_APPEND, 100, MAX_LEN + 1, 1);
      send_item(CMD_APPEND, 100, 10, 1);
      send_item(CMD_APPEND, 105, 5, 0);
      send_item(CMD_APPEND, START_TOP - MAX_LEN, MAX_LEN, 0);
      send_item(CMD_APPEND, START_TOP - 1, 1, 1);
      // Empty span, no range before the end, trims, split and delete.
      send_item(CMD_CLEAR, 50, 0, 0);
      send_item(CMD_CLEAR, 0, 100, 0);
      send_item(CMD_CLEAR, 108, 10, 0);
      send_item(CMD_CLEAR, 95, 7, 0);
      send_item(CMD_CLEAR, 104, 2, 0);
      send_item(CMD_CLEAR, 100, 20, 0);
      send_item(CMD_CLEAR, START_TOP - 1, 64'h7FFF_FFFF, 1);
      clear_table();
      // Rounding of the span to whole blocks.
      write_shift(15);
      send_item(CMD_APPEND, 10, 6, 1);
      send_item(CMD_CLEAR, (64'd11 << 15) + 1, 64'd2 << 15, 0);
      send_item(CMD_CLEAR, (64'd13 << 15) - 1, (64'd1 << 15) + 2, 0);
      send_item(CMD_CLEAR, 64'd10 << 15, 64'd1 << 15, 0);
      send_item(CMD_CLEAR, START_TOP - 1, 64'h7FFF_FFFF, 0);
      clear_table();
   endtask

   task automatic test_full_table;
      longint unsigned base;
      write_shift(0);
      base = 0;
      gaps_on = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         send_item(CMD_APPEND, base + $urandom_range(0, 40), $urandom_range(3, MAX_LEN),
                   1'($urandom_range(0, 1)));
         base = tbl_start[tbl_total-1] + tbl_len[tbl_total-1];
         if (i == 100) gaps_on = 1'b1;
      end
      send_item(CMD_APPEND, base + 1, 1, 0);
      // Splits on a full table fail; a delete frees room for one.
      for (int k = 0; k < 3; k++) begin
         int idx;
         idx = $urandom_range(0, DEPTH - 1);
         send_item(CMD_CLEAR, tbl_start[idx] + 1, 1, 0);
      end
      send_item(CMD_CLEAR, tbl_start[200], tbl_len[200], 0);
      send_item(CMD_CLEAR, tbl_start[300] + 1, 1, 0);
      clear_table();
   endtask

   task automatic test_random_mix(logic [SHIFT_W-1:0] sh, int count);
      int r;
      write_shift(sh);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) gaps_on = $urandom_range(0, 2) != 0;
         r = $urandom_range(0, 99);
         if (r < 55) send_good_append();
         else if (r < 92) send_aimed_clear();
         else send_item(1'($urandom_range(0, 1)), {$urandom, $urandom},
                        64'($urandom) & 64'h7FFF_FFFF, 1'($urandom_range(0, 1)));
      end
   endtask

   // Compare each result strobe with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_item);
            errors++;
         end else begin
            rsp_item_type want;
            want = expected_results.pop_front();
            if (rsp_item.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_item.status);
               errors++;
            end
            if (rsp_item.entry_count !== want.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d", $time,
                        want.entry_count, rsp_item.entry_count);
               errors++;
            end
            if (rsp_item.changed_flag !== want.changed_flag) begin
               $display("%0t: changed_flag expected %0d actual %0d", $time,
                        want.changed_flag, rsp_item.changed_flag);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted item or result.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_random_mix(0, 24);
      test_random_mix(15, 16);
      test_random_mix(3, 16);
      test_random_mix(SHIFT_W'($urandom_range(1, 14)), 16);
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         if (expected_results.size() != 0)
            $display("%0t: %0d results never arrived", $time, expected_results.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
